/* src/stp_pkg.sv */
//------------------------------------------------------------------------------
// stp_pkg
// shared types, role codes, register indexes and widths for the spanning
// tree port role update block
//------------------------------------------------------------------------------
`default_nettype none

package stp_pkg;

	localparam int NUM_PORTS_DEF = 8;

	localparam int ID_W    = 64;
	localparam int COST_W  = 32;
	localparam int AGE_W   = 16;
	localparam int PORT_W  = 3;
	localparam int PCOST_W = 28;
	localparam int ROLE_W  = 2;
	localparam int ROLES_W = 16;

	localparam int IN_DATA_W  = 184;
	localparam int OUT_DATA_W = 136;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 64;

	localparam logic [ROLE_W-1:0] ROLE_ROOT       = 2'd0;
	localparam logic [ROLE_W-1:0] ROLE_DESIGNATED = 2'd1;
	localparam logic [ROLE_W-1:0] ROLE_BLOCKING   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PORT_COST = 1'd1;

	localparam logic [ID_W-1:0]    OWN_ID_RESET    = 64'h8001_0000_0000_0000;
	localparam logic [PCOST_W-1:0] PORT_COST_RESET = 28'd20000;
	localparam logic [COST_W-1:0]  COST_MAX        = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [PORT_W-1:0] port_index;
		logic [ID_W-1:0]   adv_root_id;
		logic [COST_W-1:0] adv_path_cost;
		logic [AGE_W-1:0]  adv_message_age;
		logic [ID_W-1:0]   sender_id;
	} stp_item_t;

	typedef struct packed {
		logic [ID_W-1:0]   root_id;
		logic [COST_W-1:0] root_cost;
		logic [AGE_W-1:0]  msg_age;
	} stp_state_t;

endpackage

`default_nettype wire

/* src/stp_role_calc.sv */
//------------------------------------------------------------------------------
// stp_role_calc
// next root, cost, age and port roles for one received configuration bpdu
//------------------------------------------------------------------------------
`default_nettype none

module stp_role_calc #(
	parameter int NUM_PORTS = stp_pkg::NUM_PORTS_DEF
) (
	input  stp_pkg::stp_item_t                          item,
	input  stp_pkg::stp_state_t                         state,
	input  logic [NUM_PORTS-1:0][stp_pkg::ROLE_W-1:0]   roles,
	input  logic [stp_pkg::ID_W-1:0]                    own_id,
	input  logic [stp_pkg::PCOST_W-1:0]                 port_cost,
	output stp_pkg::stp_state_t                         state_n,
	output logic [NUM_PORTS-1:0][stp_pkg::ROLE_W-1:0]   roles_n,
	output logic [stp_pkg::ROLE_W-1:0]                  this_role,
	output logic [stp_pkg::ROLES_W-1:0]                 all_roles
);
	import stp_pkg::*;

	localparam logic [5:0] NP = 6'(NUM_PORTS);

	logic [COST_W:0]                    sum;
	logic                               in_range;
	logic                               adv_better;
	logic                               own_better;
	logic [NUM_PORTS-1:0]               port_sel;
	logic [ID_W-1:0]                    root1;
	logic [ID_W-1:0]                    root2;
	logic [COST_W-1:0]                  cost1;
	logic [COST_W-1:0]                  cost2;
	logic [AGE_W-1:0]                   age1;
	logic [NUM_PORTS-1:0][ROLE_W-1:0]   roles1;
	logic [NUM_PORTS-1:0][ROLE_W-1:0]   roles2;
	logic [NUM_PORTS-1:0][ROLE_W-1:0]   roles3;
	logic [ROLE_W-1:0]                  role_p;
	logic [ROLE_W-1:0]                  role_f;

	always_comb begin
		sum = {1'b0, item.adv_path_cost} + {{(COST_W + 1 - PCOST_W){1'b0}}, port_cost};
		in_range = {3'b000, item.port_index} < NP;
		for (int i = 0; i < NUM_PORTS; i++) begin
			port_sel[i] = 5'(i) == {2'b00, item.port_index};
		end

		// better advertised root
		adv_better = item.adv_root_id < state.root_id;
		root1  = state.root_id;
		cost1  = state.root_cost;
		age1   = state.msg_age;
		roles1 = roles;
		if (adv_better) begin
			root1 = item.adv_root_id;
			cost1 = sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
			age1  = item.adv_message_age;
			for (int i = 0; i < NUM_PORTS; i++) begin
				if (port_sel[i]) begin
					roles1[i] = ROLE_ROOT;
				end else if (roles[i] == ROLE_ROOT) begin
					roles1[i] = ROLE_DESIGNATED;
				end
			end
		end

		// own id beats held root
		own_better = own_id < root1;
		root2  = root1;
		cost2  = cost1;
		roles2 = roles1;
		if (own_better) begin
			root2  = own_id;
			cost2  = '0;
			roles2 = {NUM_PORTS{ROLE_DESIGNATED}};
		end

		role_p = ROLE_ROOT;
		for (int i = 0; i < NUM_PORTS; i++) begin
			if (port_sel[i]) begin
				role_p = roles2[i];
			end
		end

		role_f = role_p;
		if (role_p == ROLE_BLOCKING) begin
			if (root2 < item.adv_root_id) begin
				role_f = ROLE_DESIGNATED;
			end
			if (root2 == item.adv_root_id &&
			    ({1'b0, cost2} < sum ||
			     ({1'b0, cost2} == sum && own_id < item.sender_id))) begin
				role_f = ROLE_DESIGNATED;
			end
		end
		if (role_f == ROLE_DESIGNATED && {1'b0, cost2} > sum) begin
			role_f = ROLE_BLOCKING;
		end

		roles3 = roles2;
		for (int i = 0; i < NUM_PORTS; i++) begin
			if (port_sel[i]) begin
				roles3[i] = role_f;
			end
		end

		if (in_range) begin
			state_n.root_id   = root2;
			state_n.root_cost = cost2;
			state_n.msg_age   = age1;
			roles_n           = roles3;
			this_role         = role_f;
		end else begin
			state_n   = state;
			roles_n   = roles;
			this_role = ROLE_ROOT;
		end
	end

	// ports 0 to 7 only, missing ports read as zero
	for (genvar g = 0; g < 8; g++) begin : g_pack
		if (g < NUM_PORTS) begin : g_port
			assign all_roles[2*g +: 2] = roles_n[g];
		end else begin : g_none
			assign all_roles[2*g +: 2] = 2'b00;
		end
	end

endmodule

`default_nettype wire

/* src/stp_port_role_update.sv */
//------------------------------------------------------------------------------
// stp_port_role_update
// spanning tree root election and port role update, unless stalled one bpdu word per cycle
//------------------------------------------------------------------------------
// channel   direction  handshake          payload
// s_*       in         s_tvalid/s_tready  received bpdu fields
// m_*       out        m_tvalid/m_tready  roles, root id, root cost, age
// cfg_*     in         cfg_we             own bridge id, port cost
//
// one word per cycle sustained while m_tready is high; a word waits in the input
// register, where the compare chain on the held root and cost updates state
// reset loads the default own id as root, zero cost and age, all ports
// designated; no clearing pass
// with m_tready low one result waits in the output register and one word in
// the input register, then s_tready drops
//------------------------------------------------------------------------------
`default_nettype none

module stp_port_role_update #(
	parameter int NUM_PORTS = stp_pkg::NUM_PORTS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// port_index, adv_root_id, adv_path_cost, adv_message_age, sender_id, pad
	input  logic [stp_pkg::IN_DATA_W-1:0]      s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// all_port_roles, this_port_role, current_root_id, current_root_cost,
	// current_message_age, pad
	output logic [stp_pkg::OUT_DATA_W-1:0]     m_tdata,
	input  logic                               cfg_we,
	input  logic [stp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [stp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import stp_pkg::*;

	logic                               in_valid_s1;
	logic [IN_DATA_W-1:0]               in_data_s1;
	logic                               out_valid_s2;
	logic [OUT_DATA_W-1:0]              out_data_s2;
	logic                               advance;

	logic [ID_W-1:0]                    own_id_q;
	logic [PCOST_W-1:0]                 port_cost_q;
	stp_state_t                         state_q;
	logic [NUM_PORTS-1:0][ROLE_W-1:0]   roles_q;

	stp_item_t                          item;
	stp_state_t                         state_n;
	logic [NUM_PORTS-1:0][ROLE_W-1:0]   roles_n;
	logic [ROLE_W-1:0]                  this_role;
	logic [ROLES_W-1:0]                 all_roles;
	logic [NUM_PORTS-1:0]               root_flags;

	assign advance  = in_valid_s1 & (~out_valid_s2 | m_tready);
	assign s_tready = ~in_valid_s1 | advance;
	assign m_tvalid = out_valid_s2;
	assign m_tdata  = out_data_s2;

	assign item.port_index      = in_data_s1[2:0];
	assign item.adv_root_id     = in_data_s1[66:3];
	assign item.adv_path_cost   = in_data_s1[98:67];
	assign item.adv_message_age = in_data_s1[114:99];
	assign item.sender_id       = in_data_s1[178:115];

	stp_role_calc #(
		.NUM_PORTS (NUM_PORTS)
	) u_calc (
		.item      (item),
		.state     (state_q),
		.roles     (roles_q),
		.own_id    (own_id_q),
		.port_cost (port_cost_q),
		.state_n   (state_n),
		.roles_n   (roles_n),
		.this_role (this_role),
		.all_roles (all_roles)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_data_s1 <= s_tdata;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (m_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_s2 <= {6'b0, state_n.msg_age, state_n.root_cost, state_n.root_id,
			                this_role, all_roles};
		end
	end

	// bridge state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q    <= OWN_ID_RESET;
			port_cost_q <= PORT_COST_RESET;
			state_q     <= '{root_id: OWN_ID_RESET, root_cost: '0, msg_age: '0};
			roles_q     <= {NUM_PORTS{ROLE_DESIGNATED}};
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OWN_ID: begin
					own_id_q <= cfg_wdata;
					state_q  <= '{root_id: cfg_wdata, root_cost: '0, msg_age: '0};
				end
				CFG_PORT_COST: begin
					port_cost_q <= cfg_wdata[PCOST_W-1:0];
				end
				default: begin
				end
			endcase
		end else if (advance) begin
			state_q <= state_n;
			roles_q <= roles_n;
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_PORTS; i++) begin
			root_flags[i] = roles_q[i] == ROLE_ROOT;
		end
	end

	a_one_root_port: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(root_flags) <= 1)
		else $error("more than one root port");

	a_root_not_worse_than_own: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.root_id <= own_id_q)
		else $error("held root worse than own bridge id");

	a_own_root_zero_cost: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.root_id == own_id_q |-> state_q.root_cost == '0)
		else $error("own bridge is root with nonzero cost");

	a_result_follows_word: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_s2)
		else $error("accepted word produced no result");

	a_role_code_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 |-> out_data_s2[17:16] != 2'd3)
		else $error("result role code unused");

endmodule

`default_nettype wire

/* dv/stp_port_role_update_test.sv */
//------------------------------------------------------------------------------
// stp_port_role_update_test
// self-checking bench for the spanning tree root election and port role block
//
// a directed table covers the first root learned, the worst advertised values,
// blocking and designated moves, own id reloads, cost saturation and id
// compares on priority, extension and mac. random phases follow, each with new
// register settings, where most words advertise roots close to the held one and
// many costs close to the held cost. every result word is checked against a local predictor or a typed expectation.
// both stream sides idle at random.
//------------------------------------------------------------------------------
`default_nettype none

module stp_port_role_update_test;

	import stp_pkg::*;

	localparam int NUM_PORTS      = NUM_PORTS_DEF;
	localparam int RAND_PHASES    = 6;
	localparam int WORDS_PER_PHASE = 310;
	localparam int CYCLE_LIMIT    = 1_000_000;

	typedef struct {
		logic [ROLES_W-1:0] roles;
		logic [ROLE_W-1:0]  this_role;
		logic [ID_W-1:0]    root_id;
		logic [COST_W-1:0]  root_cost;
		logic [AGE_W-1:0]   msg_age;
	} role_update_t;

	typedef struct {
		bit                    is_write;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		stp_item_t             bpdu;
		bit                    typed;
		role_update_t          want;
	} plan_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	// predictor copy of registers and state
	logic [ID_W-1:0]    own_id;
	logic [PCOST_W-1:0] link_cost;
	logic [ID_W-1:0]    held_root;
	logic [COST_W-1:0]  held_cost;
	logic [AGE_W-1:0]   held_age;
	logic [ROLE_W-1:0]  role_tab [NUM_PORTS];

	role_update_t expected_updates [$];
	plan_row_t    plan [$];

	int  words_sent;
	int  directed_words;
	int  results_checked;
	int  mismatches;
	int  reg_writes;
	int  cycles;
	int  rx_hold;
	bit  tx_calm;
	bit  rx_calm;

	stp_port_role_update u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles,
				expected_updates.size());
			$display("status: fail");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// receiver stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (rx_hold > 0) begin
			rx_hold  <= rx_hold - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (!rx_calm && $urandom_range(3) == 0)
				rx_hold <= pick_gap();
		end
		if ($urandom_range(299) == 0)
			rx_calm <= !rx_calm;
	end

	function automatic role_update_t elect_roles(stp_item_t b);
		logic [COST_W:0] path_sum;
		logic [COST_W:0] held_wide;
		role_update_t    r;
		int              p;
		path_sum = {1'b0, b.adv_path_cost} + {5'b0, link_cost};
		p = int'(b.port_index);
		r.this_role = ROLE_ROOT;
		if (p < NUM_PORTS) begin
			if (b.adv_root_id < held_root) begin
				held_root = b.adv_root_id;
				held_cost = path_sum[COST_W] ? COST_MAX : path_sum[COST_W-1:0];
				held_age  = b.adv_message_age;
				for (int i = 0; i < NUM_PORTS; i++)
					if (role_tab[i] == ROLE_ROOT)
						role_tab[i] = ROLE_DESIGNATED;
				role_tab[p] = ROLE_ROOT;
			end
			if (own_id < held_root) begin
				held_root = own_id;
				held_cost = '0;
				for (int i = 0; i < NUM_PORTS; i++)
					role_tab[i] = ROLE_DESIGNATED;
			end
			held_wide = {1'b0, held_cost};
			if (role_tab[p] == ROLE_BLOCKING) begin
				if (held_root < b.adv_root_id)
					role_tab[p] = ROLE_DESIGNATED;
				if (held_root == b.adv_root_id && (held_wide < path_sum ||
						(held_wide == path_sum && own_id < b.sender_id)))
					role_tab[p] = ROLE_DESIGNATED;
			end
			if (role_tab[p] == ROLE_DESIGNATED && held_wide > path_sum)
				role_tab[p] = ROLE_BLOCKING;
			r.this_role = role_tab[p];
		end
		r.roles = '0;
		for (int i = 0; i < NUM_PORTS && i < 8; i++)
			r.roles[2*i +: 2] = role_tab[i];
		r.root_id   = held_root;
		r.root_cost = held_cost;
		r.msg_age   = held_age;
		return r;
	endfunction

	// bpdu close to the held root most of the time, often near the held cost
	function automatic stp_item_t gen_bpdu();
		stp_item_t         b;
		int                r;
		logic [COST_W-1:0] base;
		b.port_index = 3'($urandom_range(0, 7));
		r = $urandom_range(99);
		if (r < 35)
			b.adv_root_id = held_root;
		else if (r < 55)
			b.adv_root_id = held_root - $urandom_range(1, 3);
		else if (r < 70)
			b.adv_root_id = held_root + $urandom_range(1, 3);
		else if (r < 78)
			b.adv_root_id = own_id;
		else if (r < 85)
			b.adv_root_id = {held_root[63:48], 16'($urandom), 32'($urandom)};
		else
			b.adv_root_id = {32'($urandom), 32'($urandom)};
		base = held_cost - {4'b0, link_cost};
		r = $urandom_range(99);
		if (r < 40)
			b.adv_path_cost = base + $urandom_range(0, 4) - 2;
		else if (r < 55)
			b.adv_path_cost = '0;
		else if (r < 65)
			b.adv_path_cost = COST_MAX;
		else if (r < 80)
			b.adv_path_cost = $urandom_range(0, 1000);
		else
			b.adv_path_cost = $urandom;
		b.adv_message_age = 16'($urandom);
		r = $urandom_range(99);
		if (r < 30)
			b.sender_id = own_id;
		else if (r < 45)
			b.sender_id = r[0] ? own_id + 1 : own_id - 1;
		else
			b.sender_id = {32'($urandom), 32'($urandom)};
		return b;
	endfunction

	task automatic send_bpdu(stp_item_t b);
		expected_updates.push_back(elect_roles(b));
		s_tdata  <= {5'b0, b.sender_id, b.adv_message_age, b.adv_path_cost,
			b.adv_root_id, b.port_index};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		words_sent++;
		if (!tx_calm && $urandom_range(2) == 0) begin
			s_tvalid <= 1'b0;
			repeat (pick_gap()) @(posedge clk);
		end
		if ($urandom_range(99) == 0)
			tx_calm = !tx_calm;
	endtask

	task automatic send_typed(stp_item_t b, role_update_t want);
		void'(elect_roles(b));
		expected_updates.push_back(want);
		s_tdata  <= {5'b0, b.sender_id, b.adv_message_age, b.adv_path_cost,
			b.adv_root_id, b.port_index};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		words_sent++;
		if (!tx_calm && $urandom_range(2) == 0) begin
			s_tvalid <= 1'b0;
			repeat (pick_gap()) @(posedge clk);
		end
	endtask

	task automatic apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		s_tvalid <= 1'b0;
		while (expected_updates.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		reg_writes++;
		if (idx == CFG_OWN_ID) begin
			own_id    = val;
			held_root = val;
			held_cost = '0;
			held_age  = '0;
		end else if (idx == CFG_PORT_COST) begin
			link_cost = val[PCOST_W-1:0];
		end
	endtask

	function automatic plan_row_t bpdu_row(logic [PORT_W-1:0] port, logic [ID_W-1:0] root,
			logic [COST_W-1:0] cost, logic [AGE_W-1:0] age, logic [ID_W-1:0] sender);
		plan_row_t r;
		r.is_write  = 1'b0;
		r.reg_idx   = '0;
		r.reg_val   = '0;
		r.bpdu.port_index      = port;
		r.bpdu.adv_root_id     = root;
		r.bpdu.adv_path_cost   = cost;
		r.bpdu.adv_message_age = age;
		r.bpdu.sender_id       = sender;
		r.typed = 1'b0;
		r.want  = '{default: '0};
		return r;
	endfunction

	function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] val);
		plan_row_t r;
		r = bpdu_row('0, '0, '0, '0, '0);
		r.is_write = 1'b1;
		r.reg_idx  = idx;
		r.reg_val  = val;
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		role_update_t want;
		role_update_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.roles     = m_tdata[15:0];
			got.this_role = m_tdata[17:16];
			got.root_id   = m_tdata[81:18];
			got.root_cost = m_tdata[113:82];
			got.msg_age   = m_tdata[129:114];
			if (expected_updates.size() == 0) begin
				$error("result word with nothing expected: %h", m_tdata);
				mismatches++;
			end else begin
				want = expected_updates.pop_front();
				results_checked++;
				if (got.roles !== want.roles) begin
					$error("all_port_roles: expected %h, got %h", want.roles, got.roles);
					mismatches++;
				end
				if (got.this_role !== want.this_role) begin
					$error("this_port_role: expected %0d, got %0d", want.this_role,
						got.this_role);
					mismatches++;
				end
				if (got.root_id !== want.root_id) begin
					$error("current_root_id: expected %h, got %h", want.root_id,
						got.root_id);
					mismatches++;
				end
				if (got.root_cost !== want.root_cost) begin
					$error("current_root_cost: expected %h, got %h", want.root_cost,
						got.root_cost);
					mismatches++;
				end
				if (got.msg_age !== want.msg_age) begin
					$error("current_message_age: expected %h, got %h", want.msg_age,
						got.msg_age);
					mismatches++;
				end
			end
		end
	end

	initial begin
		plan_row_t          r;
		logic [ID_W-1:0]    new_own;
		logic [PCOST_W-1:0] new_cost;

		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		m_tready  = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		cycles    = 0;
		rx_hold   = 0;
		tx_calm   = 1'b0;
		rx_calm   = 1'b0;
		words_sent      = 0;
		results_checked = 0;
		mismatches      = 0;
		reg_writes      = 0;

		own_id    = OWN_ID_RESET;
		link_cost = PORT_COST_RESET;
		held_root = OWN_ID_RESET;
		held_cost = '0;
		held_age  = '0;
		for (int i = 0; i < NUM_PORTS; i++)
			role_tab[i] = ROLE_DESIGNATED;

		// first root learned on port 0
		r = bpdu_row(3'd0, 64'h0, 32'h0, 16'h1234, 64'h0);
		r.typed = 1'b1;
		r.want  = '{roles: 16'h5554, this_role: ROLE_ROOT, root_id: 64'h0,
			root_cost: 32'd20000, msg_age: 16'h1234};
		plan.push_back(r);
		// worst advertised values change nothing
		r = bpdu_row(3'd7, '1, '1, '1, '1);
		r.typed = 1'b1;
		r.want  = '{roles: 16'h5554, this_role: ROLE_DESIGNATED, root_id: 64'h0,
			root_cost: 32'd20000, msg_age: 16'h1234};
		plan.push_back(r);
		plan.push_back(bpdu_row(3'd3, 64'h0, 32'd0, 16'h0, 64'h0));
		plan.push_back(reg_row(CFG_PORT_COST, 64'd0));
		// blocking and back to designated
		plan.push_back(bpdu_row(3'd3, 64'h0, 32'd0, 16'h1, 64'h0));
		plan.push_back(bpdu_row(3'd3, 64'h0, 32'd5, 16'h2, 64'h0));
		plan.push_back(bpdu_row(3'd3, 64'h0, 32'd20000, 16'h3, '1));
		plan.push_back(bpdu_row(3'd3, 64'h0, 32'd0, 16'h4, 64'h0));
		plan.push_back(bpdu_row(3'd3, '1, '1, 16'h5, 64'h0));
		plan.push_back(bpdu_row(3'd3, 64'h0, 32'd100, 16'h6, 64'h0));
		plan.push_back(bpdu_row(3'd3, 64'h0, 32'd20000, 16'h7, 64'h0));
		plan.push_back(bpdu_row(3'd3, 64'h0, 32'd30000, 16'h8, 64'h0));
		// own id reloads
		plan.push_back(reg_row(CFG_OWN_ID, 64'h0));
		plan.push_back(bpdu_row(3'd2, 64'h0, 32'd0, 16'h9, 64'h0));
		plan.push_back(reg_row(CFG_OWN_ID, '1));
		plan.push_back(reg_row(CFG_PORT_COST, 64'd200_000_000));
		// path sum overflow saturates the stored cost
		r = bpdu_row(3'd5, 64'hFFFF_FFFF_FFFF_FFFE, '1, 16'h0007, 64'h0);
		r.typed = 1'b1;
		r.want  = '{roles: 16'h5155, this_role: ROLE_ROOT, root_id: 64'hFFFF_FFFF_FFFF_FFFE,
			root_cost: 32'hFFFF_FFFF, msg_age: 16'h0007};
		plan.push_back(r);
		plan.push_back(bpdu_row(3'd6, 64'hFFFF_FFFF_FFFF_FFFE, 32'd0, 16'hA, 64'h0));
		// mac, priority, then extension decide
		plan.push_back(bpdu_row(3'd1, 64'hFFFF_FFFF_FFFF_FFFD, 32'd10, 16'hB, '1));
		plan.push_back(bpdu_row(3'd4, 64'h7FFF_FFFF_FFFF_FFFF, 32'd10, 16'hC, '1));
		plan.push_back(bpdu_row(3'd0, 64'h7FFE_FFFF_FFFF_FFFF, 32'd10, 16'hD, '1));
		plan.push_back(bpdu_row(3'd2, 64'h7FFE_0000_0000_0000, 32'd10, 16'hE, '1));
		plan.push_back(bpdu_row(3'd2, 64'h7FFE_0000_0000_0000, 32'd0, 16'hF, 64'h0));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_write)
				apply_reg(plan[i].reg_idx, plan[i].reg_val);
			else if (plan[i].typed)
				send_typed(plan[i].bpdu, plan[i].want);
			else
				send_bpdu(plan[i].bpdu);
		end
		directed_words = words_sent;

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
				0: begin
					new_own  = {32'($urandom), 32'($urandom)};
					new_cost = PORT_COST_RESET;
				end
				1: begin
					new_own  = '1;
					new_cost = 28'd200_000_000;
				end
				2: begin
					new_own  = '0;
					new_cost = '0;
				end
				default: begin
					new_own  = {8'h80, 8'($urandom), 16'($urandom), 32'($urandom)};
					new_cost = 28'($urandom_range(0, 200_000_000));
				end
			endcase
			apply_reg(CFG_PORT_COST, {36'b0, new_cost});
			apply_reg(CFG_OWN_ID, new_own);
			repeat (WORDS_PER_PHASE)
				send_bpdu(gen_bpdu());
		end

		s_tvalid <= 1'b0;
		while (expected_updates.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("summary: %0d bpdu words (%0d directed), %0d results checked", words_sent,
			directed_words, results_checked);
		$display("summary: %0d register writes over %0d random phases, %0d mismatches",
			reg_writes, RAND_PHASES, mismatches);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire

/* files.f */
src/stp_pkg.sv
src/stp_role_calc.sv
src/stp_port_role_update.sv
dv/stp_port_role_update_test.sv
